// ===== src/volume_box_mean_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the volume box mean filter
// Concurrent checks on clk, held off while rst is high. Define NO_ASSERTIONS
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef VOLUME_BOX_MEAN_FILTER_CORE_MACROS_SVH
`define VOLUME_BOX_MEAN_FILTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define VBMF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vbmf: same-cycle check failed");

// next-cycle implication
`define VBMF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vbmf: next-cycle check failed");

`else

`define VBMF_ASSERT_IMPL(name, ante, cons)
`define VBMF_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== src/vbmf_pkg.sv =====
// ----------------------------------------------------------------------------
// vbmf_pkg
// Shared codes, register indexes and output limits of the box mean filter.
// ----------------------------------------------------------------------------
package vbmf_pkg;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SIZE_X   = 3'd0;
  localparam cfg_idx_t CFG_SIZE_Y   = 3'd1;
  localparam cfg_idx_t CFG_SIZE_Z   = 3'd2;
  localparam cfg_idx_t CFG_RADIUS_X = 3'd3;
  localparam cfg_idx_t CFG_RADIUS_Y = 3'd4;
  localparam cfg_idx_t CFG_RADIUS_Z = 3'd5;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int POS_W   = 5;
  localparam int SIZE_W  = 6;
  localparam int RAD_W   = 3;
  localparam int VAL_W   = 16;
  localparam int COUNT_W = 10;
  localparam int CFG_W   = 6;

  localparam logic signed [VAL_W-1:0] MEAN_MAX = 16'sh7fff;
  localparam logic signed [VAL_W-1:0] MEAN_MIN = -16'sh8000;

  localparam logic [SIZE_W-1:0] SIZE_RESET   = 6'd32;
  localparam logic [RAD_W-1:0]  RADIUS_RESET = 3'd2;

endpackage

// ===== src/vbmf_ram.sv =====
// ----------------------------------------------------------------------------
// vbmf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vbmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/volume_box_mean_filter_core.sv =====
// ----------------------------------------------------------------------------
// volume_box_mean_filter_core
// 3D box mean filter over one voxel volume held in a single RAM.
//
//   channel | direction | handshake          | payload
//   cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall  | mode, pos_x/y/z, voxel_value
//   out     | out       | out_valid/stall    | mean_value, voxel_count
//
// A load writes the voxel on the transfer edge.
// A query reads the N in-bounds box voxels (up to 729, one RAM read a
// cycle), then runs SUM_W (26 by default) steps of the bit-serial divider.
// A query with an empty box skips the walk and the divider. No further
// item is taken while a query runs.
// The result waits in an output register; a stalled output holds the query
// in its final state. rst is synchronous; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "volume_box_mean_filter_core_macros.svh"

module volume_box_mean_filter_core
  import vbmf_pkg::*;
#(
  parameter int DIM_MAX    = 32,
  parameter int RADIUS_MAX = 4,
  parameter int VOXEL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic [POS_W-1:0]         pos_x,
  input  logic [POS_W-1:0]         pos_y,
  input  logic [POS_W-1:0]         pos_z,
  input  logic signed [VAL_W-1:0]  voxel_value,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  mean_value,
  output logic [COUNT_W-1:0]       voxel_count
);

  localparam int AW      = $clog2(DIM_MAX);
  localparam int CW      = ((AW > POS_W) ? AW : POS_W) + 3;
  localparam int DEPTH   = 1 << (3 * AW);
  localparam int CNT_MAX = (2 * RADIUS_MAX + 1) * (2 * RADIUS_MAX + 1)
                           * (2 * RADIUS_MAX + 1);
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int SUM_W   = VOXEL_BITS + CNT_W;
  localparam int STEP_W  = $clog2(SUM_W + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic signed [CW-1:0] DIM_C = CW'(DIM_MAX);
  localparam logic signed [CW-1:0] RAD_C = CW'(RADIUS_MAX);
  localparam logic signed [CW-1:0] ONE_C = CW'(1);

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [RAD_W-1:0]  radius_x, radius_y, radius_z;

  logic [2:0]               state;
  logic signed [CW-1:0]     cx, cy, cz;
  logic signed [CW-1:0]     x_lo, x_hi, y_lo, y_hi, z_hi;
  logic                     rd_pending;
  logic signed [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         rem;
  logic [SUM_W-1:0]         dvd;
  logic                     neg;
  logic [STEP_W-1:0]        step_cnt;

  logic                     in_xfer, out_free;
  logic                     ram_we;
  logic [3*AW-1:0]          ram_waddr, ram_raddr;
  logic [VOXEL_BITS-1:0]    ram_rdata;
  logic signed [CW-1:0]     sx_c, sy_c, sz_c, rx_c, ry_c, rz_c;
  logic signed [CW-1:0]     px_s, py_s, pz_s;
  logic signed [CW-1:0]     x_lo_next, x_hi_next, y_lo_next, y_hi_next;
  logic signed [CW-1:0]     z_lo_next, z_hi_next;
  logic                     box_empty;
  logic [CNT_W:0]           rem_sh;
  logic                     q_bit;
  logic signed [SUM_W:0]    quo_s;
  logic signed [VAL_W-1:0]  mean_sat;

  function automatic logic signed [CW-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
    logic signed [CW-1:0] w;
    w = CW'(v);
    if (w == 0) begin
      return ONE_C;
    end else if (w > DIM_C) begin
      return DIM_C;
    end
    return w;
  endfunction

  function automatic logic signed [CW-1:0] clamp_rad(input logic [RAD_W-1:0] v);
    logic signed [CW-1:0] w;
    w = CW'(v);
    if (w == 0) begin
      return ONE_C;
    end else if (w > RAD_C) begin
      return RAD_C;
    end
    return w;
  endfunction

  function automatic logic signed [CW-1:0] lo_bound(input logic signed [CW-1:0] p,
                                                    input logic signed [CW-1:0] r);
    logic signed [CW-1:0] d;
    d = p - r;
    return (d < 0) ? '0 : d;
  endfunction

  function automatic logic signed [CW-1:0] hi_bound(input logic signed [CW-1:0] p,
                                                    input logic signed [CW-1:0] r,
                                                    input logic signed [CW-1:0] s);
    logic signed [CW-1:0] d;
    d = p + r;
    return (d > s - ONE_C) ? s - ONE_C : d;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x   <= SIZE_RESET;
      size_y   <= SIZE_RESET;
      size_z   <= SIZE_RESET;
      radius_x <= RADIUS_RESET;
      radius_y <= RADIUS_RESET;
      radius_z <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE_X:   size_x   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:   size_y   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:   size_z   <= cfg_data[SIZE_W-1:0];
        CFG_RADIUS_X: radius_x <= cfg_data[RAD_W-1:0];
        CFG_RADIUS_Y: radius_y <= cfg_data[RAD_W-1:0];
        CFG_RADIUS_Z: radius_z <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sx_c = clamp_dim(size_x);
    sy_c = clamp_dim(size_y);
    sz_c = clamp_dim(size_z);
    rx_c = clamp_rad(radius_x);
    ry_c = clamp_rad(radius_y);
    rz_c = clamp_rad(radius_z);
    px_s = CW'(pos_x);
    py_s = CW'(pos_y);
    pz_s = CW'(pos_z);
    x_lo_next = lo_bound(px_s, rx_c);
    x_hi_next = hi_bound(px_s, rx_c, sx_c);
    y_lo_next = lo_bound(py_s, ry_c);
    y_hi_next = hi_bound(py_s, ry_c, sy_c);
    z_lo_next = lo_bound(pz_s, rz_c);
    z_hi_next = hi_bound(pz_s, rz_c, sz_c);
    box_empty = (x_lo_next > x_hi_next) || (y_lo_next > y_hi_next)
             || (z_lo_next > z_hi_next);
  end

  assign ram_we = in_xfer && (mode == MODE_LOAD)
               && (CW'(pos_x) < DIM_C) && (CW'(pos_y) < DIM_C) && (CW'(pos_z) < DIM_C);
  assign ram_waddr = {AW'(pos_z), AW'(pos_y), AW'(pos_x)};
  assign ram_raddr = {AW'(cz), AW'(cy), AW'(cx)};

  vbmf_ram #(
    .WIDTH (VOXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (VOXEL_BITS'(voxel_value)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    rem_sh = {rem, dvd[SUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, count});
    quo_s  = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
    if (quo_s > (SUM_W+1)'(MEAN_MAX)) begin
      mean_sat = MEAN_MAX;
    end else if (quo_s < (SUM_W+1)'(MEAN_MIN)) begin
      mean_sat = MEAN_MIN;
    end else begin
      mean_sat = VAL_W'(quo_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      rd_pending <= (state == S_WALK);
      case (state)
        S_IDLE: begin
          if (in_xfer && (mode == MODE_QUERY)) begin
            state <= box_empty ? S_PREP : S_WALK;
          end
        end
        S_WALK: begin
          if (cx == x_hi && cy == y_hi && cz == z_hi) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_PREP;
        S_PREP:  state <= (count == '0) ? S_DONE : S_DIV;
        S_DIV: begin
          if (step_cnt == STEP_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x_lo  <= x_lo_next;
        x_hi  <= x_hi_next;
        y_lo  <= y_lo_next;
        y_hi  <= y_hi_next;
        z_hi  <= z_hi_next;
        cx    <= x_lo_next;
        cy    <= y_lo_next;
        cz    <= z_lo_next;
        sum   <= '0;
        count <= '0;
      end
      S_WALK: begin
        if (cx == x_hi) begin
          cx <= x_lo;
          if (cy == y_hi) begin
            cy <= y_lo;
            cz <= cz + ONE_C;
          end else begin
            cy <= cy + ONE_C;
          end
        end else begin
          cx <= cx + ONE_C;
        end
      end
      S_PREP: begin
        neg      <= sum[SUM_W-1];
        dvd      <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        rem      <= '0;
        step_cnt <= STEP_W'(SUM_W);
      end
      S_DIV: begin
        rem      <= q_bit ? CNT_W'(rem_sh - {1'b0, count}) : CNT_W'(rem_sh);
        dvd      <= {dvd[SUM_W-2:0], q_bit};
        step_cnt <= step_cnt - STEP_W'(1);
      end
      S_DONE: begin
        if (out_free) begin
          mean_value  <= (count == '0) ? '0 : mean_sat;
          voxel_count <= COUNT_W'(count);
        end
      end
      default: ;
    endcase
    if (rd_pending) begin
      sum   <= sum + SUM_W'($signed(ram_rdata));
      count <= count + CNT_W'(1);
    end
  end

  `VBMF_ASSERT_IMPL(a_no_write_in_query, ram_we, state == S_IDLE && !rd_pending)
  `VBMF_ASSERT_IMPL(a_count_bound, state == S_DIV, count != '0 && count <= CNT_W'(CNT_MAX))
  `VBMF_ASSERT_NEXT(a_result_held, state == S_DONE && out_valid && out_stall, state == S_DONE && $stable(mean_value) && $stable(voxel_count))

endmodule
